@@ rtl/tevq_pkg.sv @@
// Shared constants, codes and interface types of the timed event queue.
package tevq_pkg;

   localparam int SLOTS     = 32;
   localparam int TAG_BITS  = 16;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TIME_BITS = 64;
   localparam int PORT_TAG_BITS  = 16;
   localparam int STORE_TAG_BITS = (TAG_BITS < PORT_TAG_BITS) ? TAG_BITS : PORT_TAG_BITS;

   localparam logic [1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [1:0] FUNC_ADVANCE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_WRAP = 2'd2;

   typedef struct packed {
      logic [TIME_BITS-1:0]      due;
      logic [STORE_TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic                 insert;
      logic                 clear;
      logic                 scan_start;
      logic                 release_best;
      logic [TIME_BITS-1:0] limit;
      entry_type            entry;
   } tbl_cmd_type;

   typedef struct packed {
      logic                 full;
      logic                 done;
      logic                 found;
      logic [SLOT_BITS-1:0] best_slot;
      entry_type            best;
   } tbl_stat_type;

endpackage

@@ rtl/tevq_table.sv @@
// Event slot table: slot memory, pending bits, free slot search and earliest-due scan.
module tevq_table (
   input  logic                   clock,
   input  logic                   reset,
   input  tevq_pkg::tbl_cmd_type  cmd,
   output tevq_pkg::tbl_stat_type stat
);

   tevq_pkg::entry_type mem [tevq_pkg::SLOTS];

   logic [tevq_pkg::SLOTS-1:0]     pending_ff;
   logic [tevq_pkg::SLOT_BITS-1:0] free_slot;
   logic                           have_free;

   logic                           issuing_ff;
   logic [tevq_pkg::SLOT_BITS-1:0] rd_addr_ff;
   tevq_pkg::entry_type            rd_q_ff;
   logic                           rd_vld_ff;
   logic                           rd_pend_ff;
   logic                           rd_last_ff;
   logic [tevq_pkg::SLOT_BITS-1:0] rd_slot_ff;

   logic                           found_ff;
   logic                           done_ff;
   logic [tevq_pkg::SLOT_BITS-1:0] best_slot_ff;
   tevq_pkg::entry_type            best_ff;
   logic                           better;

   // lowest free slot wins
   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = tevq_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!pending_ff[i]) begin
            free_slot = tevq_pkg::SLOT_BITS'(i);
            have_free = 1'b1;
         end
      end
   end

   // strict compare keeps the lowest slot on equal due times
   assign better = rd_vld_ff && rd_pend_ff && (rd_q_ff.due <= cmd.limit)
                   && (!found_ff || (rd_q_ff.due < best_ff.due));

   always_ff @(posedge clock) begin
      if (cmd.insert && have_free) begin
         mem[free_slot] <= cmd.entry;
      end
      rd_q_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         issuing_ff <= 1'b0;
         rd_addr_ff <= '0;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         found_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         if (cmd.clear) begin
            pending_ff <= '0;
         end else if (cmd.insert && have_free) begin
            pending_ff[free_slot] <= 1'b1;
         end else if (cmd.release_best) begin
            pending_ff[best_slot_ff] <= 1'b0;
         end

         rd_vld_ff  <= issuing_ff;
         rd_pend_ff <= pending_ff[rd_addr_ff];
         rd_slot_ff <= rd_addr_ff;
         rd_last_ff <= issuing_ff && (rd_addr_ff == tevq_pkg::SLOT_BITS'(tevq_pkg::SLOTS - 1));
         done_ff    <= rd_vld_ff && rd_last_ff;

         if (cmd.scan_start) begin
            issuing_ff <= 1'b1;
            rd_addr_ff <= '0;
            found_ff   <= 1'b0;
         end else begin
            if (issuing_ff) begin
               if (rd_addr_ff == tevq_pkg::SLOT_BITS'(tevq_pkg::SLOTS - 1)) begin
                  issuing_ff <= 1'b0;
                  rd_addr_ff <= '0;
               end else begin
                  rd_addr_ff <= rd_addr_ff + tevq_pkg::SLOT_BITS'(1);
               end
            end
            if (better) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_ff      <= rd_q_ff;
         best_slot_ff <= rd_slot_ff;
      end
   end

   assign stat.full      = !have_free;
   assign stat.done      = done_ff;
   assign stat.found     = found_ff;
   assign stat.best_slot = best_slot_ff;
   assign stat.best      = best_ff;

   a_done_after_issue: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !issuing_ff && !rd_vld_ff)
      else $error("scan reported done while reads outstanding");

   a_best_pending: assert property (@(posedge clock) disable iff (reset)
      done_ff && found_ff |-> pending_ff[best_slot_ff])
      else $error("earliest event is not pending");

   a_release_found: assert property (@(posedge clock) disable iff (reset)
      cmd.release_best |-> done_ff && found_ff)
      else $error("release without a found event");

   a_insert_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && have_free && !cmd.clear |=> $countones(pending_ff)
                                              == $countones($past(pending_ff)) + 1)
      else $error("insert did not occupy a slot");

endmodule

@@ rtl/timed_event_queue.sv @@
// Top level: command handling, current time and result register of the timed event queue.
// Schedule, clear and unused codes: one result in the cycle after the item is accepted.
// Advance: one scan over the slot memory per fired event, plus a final scan that finds
// none; busy holds meanwhile.
// Overflowing advance: one result in the next cycle. The receiver cannot stall.
// Reset (synchronous): time zero, no events pending, block idle; slot memory not cleared.
module timed_event_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_func,
   input  logic [tevq_pkg::TIME_BITS-1:0]       req_due_time,
   input  logic [tevq_pkg::PORT_TAG_BITS-1:0]   req_event_tag,
   input  logic [tevq_pkg::TIME_BITS-1:0]       req_delta_ms,
   output logic                                 rsp_valid,
   output logic                                 rsp_fired,
   output logic [tevq_pkg::PORT_TAG_BITS-1:0]   rsp_fired_tag,
   output logic [tevq_pkg::TIME_BITS-1:0]       rsp_fired_time,
   output logic [1:0]                           rsp_status,
   output logic [tevq_pkg::TIME_BITS-1:0]       rsp_current_time,
   output logic                                 rsp_last
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type                       state_ff;
   logic [tevq_pkg::TIME_BITS-1:0]  now_ff;
   logic [tevq_pkg::TIME_BITS:0]    sum_in;
   logic                            accept;

   logic                            rsp_valid_ff;
   logic                            rsp_fired_ff;
   logic [tevq_pkg::PORT_TAG_BITS-1:0] rsp_tag_ff;
   logic [tevq_pkg::TIME_BITS-1:0]  rsp_time_ff;
   logic [1:0]                      rsp_status_ff;
   logic [tevq_pkg::TIME_BITS-1:0]  rsp_now_ff;
   logic                            rsp_last_ff;

   tevq_pkg::tbl_cmd_type           cmd;
   tevq_pkg::tbl_stat_type          stat;

   assign accept = start && (state_ff == ST_IDLE);
   assign sum_in = {1'b0, now_ff} + {1'b0, req_delta_ms};

   always_comb begin
      cmd              = '0;
      cmd.limit        = now_ff;
      cmd.entry.due    = req_due_time;
      cmd.entry.tag    = req_event_tag[tevq_pkg::STORE_TAG_BITS-1:0];
      cmd.insert       = accept && (req_func == tevq_pkg::FUNC_SCHEDULE);
      cmd.clear        = accept && (req_func == tevq_pkg::FUNC_CLEAR);
      cmd.scan_start   = (accept && (req_func == tevq_pkg::FUNC_ADVANCE)
                          && !sum_in[tevq_pkg::TIME_BITS])
                         || ((state_ff == ST_SCAN) && stat.done && stat.found);
      cmd.release_best = (state_ff == ST_SCAN) && stat.done && stat.found;
   end

   tevq_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_fired_ff  <= 1'b0;
                  rsp_tag_ff    <= '0;
                  rsp_time_ff   <= '0;
                  rsp_status_ff <= tevq_pkg::STATUS_OK;
                  rsp_now_ff    <= now_ff;
                  rsp_last_ff   <= 1'b1;
                  case (req_func)
                     tevq_pkg::FUNC_SCHEDULE: begin
                        if (stat.full) begin
                           rsp_status_ff <= tevq_pkg::STATUS_FULL;
                        end
                     end
                     tevq_pkg::FUNC_ADVANCE: begin
                        if (sum_in[tevq_pkg::TIME_BITS]) begin
                           rsp_status_ff <= tevq_pkg::STATUS_WRAP;
                        end else begin
                           // hold the result until the scans finish
                           rsp_valid_ff <= 1'b0;
                           now_ff       <= sum_in[tevq_pkg::TIME_BITS-1:0];
                           state_ff     <= ST_SCAN;
                        end
                     end
                     tevq_pkg::FUNC_CLEAR: begin
                        now_ff     <= '0;
                        rsp_now_ff <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (stat.done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_now_ff   <= now_ff;
                  rsp_status_ff <= tevq_pkg::STATUS_OK;
                  if (stat.found) begin
                     rsp_fired_ff <= 1'b1;
                     rsp_tag_ff   <= tevq_pkg::PORT_TAG_BITS'(stat.best.tag);
                     rsp_time_ff  <= stat.best.due;
                     rsp_last_ff  <= 1'b0;
                  end else begin
                     rsp_fired_ff <= 1'b0;
                     rsp_tag_ff   <= '0;
                     rsp_time_ff  <= '0;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_fired_tag    = rsp_tag_ff;
   assign rsp_fired_time   = rsp_time_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_current_time = rsp_now_ff;
   assign rsp_last         = rsp_last_ff;

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> !rsp_last && rsp_status == tevq_pkg::STATUS_OK)
      else $error("fired item marked last or with error status");

   a_fired_due: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_fired_time <= rsp_current_time)
      else $error("fired event not yet due");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      busy && stat.done && !stat.found |=> !busy && rsp_valid && rsp_last)
      else $error("advance did not close with a status item");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the timed event queue: command driver, result checker, table predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]                     FUNC_UNUSED = 2'd3;
   localparam logic [tevq_pkg::TIME_BITS-1:0] TIME_MAX    = '1;
   localparam int                             TAIL_CYCLES = 2 * (tevq_pkg::SLOTS + 2) + 8;

   typedef struct {
      logic [1:0]                         func;
      logic [tevq_pkg::TIME_BITS-1:0]     due;
      logic [tevq_pkg::PORT_TAG_BITS-1:0] tag;
      logic [tevq_pkg::TIME_BITS-1:0]     delta;
      int                                 gap;
      bit                                 drain;
   } command_type;

   typedef struct {
      logic                               fired;
      logic [tevq_pkg::PORT_TAG_BITS-1:0] tag;
      logic [tevq_pkg::TIME_BITS-1:0]     when;
      logic [1:0]                         status;
      logic [tevq_pkg::TIME_BITS-1:0]     now_after;
      logic                               last;
   } outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [1:0]                         req_func = tevq_pkg::FUNC_CLEAR;
   logic [tevq_pkg::TIME_BITS-1:0]     req_due_time = '0;
   logic [tevq_pkg::PORT_TAG_BITS-1:0] req_event_tag = '0;
   logic [tevq_pkg::TIME_BITS-1:0]     req_delta_ms = '0;
   logic                               rsp_valid;
   logic                               rsp_fired;
   logic [tevq_pkg::PORT_TAG_BITS-1:0] rsp_fired_tag;
   logic [tevq_pkg::TIME_BITS-1:0]     rsp_fired_time;
   logic [1:0]                         rsp_status;
   logic [tevq_pkg::TIME_BITS-1:0]     rsp_current_time;
   logic                               rsp_last;

   // predictor state
   logic [tevq_pkg::TIME_BITS-1:0]      clock_ms;
   logic [tevq_pkg::TIME_BITS-1:0]      slot_when [tevq_pkg::SLOTS];
   logic [tevq_pkg::STORE_TAG_BITS-1:0] slot_label [tevq_pkg::SLOTS];
   logic [tevq_pkg::SLOTS-1:0]          slot_busy;

   command_type                    cmd_q[$];
   outcome_type                    owed_results[$];
   command_type                    on_port;
   logic [tevq_pkg::TIME_BITS-1:0] plan_time;
   bit                             quiet;
   bit                             took;
   bit                             armed;
   int                             hold_off;
   int                             sent, checked, n_fired, n_full, n_wrap, errors;

   timed_event_queue uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_due_time(req_due_time),
      .req_event_tag(req_event_tag), .req_delta_ms(req_delta_ms),
      .rsp_valid(rsp_valid), .rsp_fired(rsp_fired), .rsp_fired_tag(rsp_fired_tag),
      .rsp_fired_time(rsp_fired_time), .rsp_status(rsp_status),
      .rsp_current_time(rsp_current_time), .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out every result an accepted command owes and update the table copy.
   task automatic apply_command(input command_type c);
      outcome_type                  o;
      logic [tevq_pkg::TIME_BITS:0] sum;
      int                           best;
      o = '{fired: 1'b0, tag: '0, when: '0, status: tevq_pkg::STATUS_OK, now_after: '0,
            last: 1'b1};
      case (c.func)
         tevq_pkg::FUNC_SCHEDULE: begin
            best = -1;
            for (int i = 0; i < tevq_pkg::SLOTS; i++)
               if (best < 0 && !slot_busy[i]) best = i;
            if (best < 0) begin
               o.status = tevq_pkg::STATUS_FULL;
               n_full++;
            end else begin
               slot_when[best]  = c.due;
               slot_label[best] = c.tag[tevq_pkg::STORE_TAG_BITS-1:0];
               slot_busy[best]  = 1'b1;
            end
         end
         tevq_pkg::FUNC_ADVANCE: begin
            sum = {1'b0, clock_ms} + {1'b0, c.delta};
            if (sum[tevq_pkg::TIME_BITS]) begin
               o.status = tevq_pkg::STATUS_WRAP;
               n_wrap++;
            end else begin
               clock_ms = sum[tevq_pkg::TIME_BITS-1:0];
               forever begin
                  best = -1;
                  for (int i = 0; i < tevq_pkg::SLOTS; i++)
                     if (slot_busy[i] && slot_when[i] <= clock_ms &&
                         (best < 0 || slot_when[i] < slot_when[best]))
                        best = i;
                  if (best < 0) break;
                  slot_busy[best] = 1'b0;
                  owed_results.push_back('{fired: 1'b1,
                                           tag: tevq_pkg::PORT_TAG_BITS'(slot_label[best]),
                                           when: slot_when[best],
                                           status: tevq_pkg::STATUS_OK,
                                           now_after: clock_ms, last: 1'b0});
                  n_fired++;
               end
            end
         end
         tevq_pkg::FUNC_CLEAR: begin
            slot_busy = '0;
            clock_ms  = '0;
         end
         default: ;
      endcase
      o.now_after = clock_ms;
      owed_results.push_back(o);
   endtask

   // Driver: present the next command once its hold-off has run out and, for a drain command, no results are owed.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         armed = 1'b0;
         clock_ms = '0;
         slot_busy = '0;
      end else begin
         took = start && !busy;
         if (took) begin
            apply_command(on_port);
            sent++;
         end
         if (!start || took) begin
            if (!armed && cmd_q.size() > 0) begin
               hold_off = cmd_q[0].gap;
               armed = 1'b1;
            end
            if (armed && hold_off == 0 && !(cmd_q[0].drain && owed_results.size() != 0)) begin
               on_port = cmd_q.pop_front();
               armed = 1'b0;
               start         <= 1'b1;
               req_func      <= on_port.func;
               req_due_time  <= on_port.due;
               req_event_tag <= on_port.tag;
               req_delta_ms  <= on_port.delta;
            end else begin
               if (armed && hold_off > 0) hold_off--;
               start <= 1'b0;
            end
         end
      end
   end

   // Checker: every strobed result against the oldest one owed.
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            $error("unexpected result: fired %0d tag %h time %h status %0d",
                   rsp_fired, rsp_fired_tag, rsp_fired_time, rsp_status);
            errors++;
         end else begin
            e = owed_results.pop_front();
            checked++;
            if (rsp_fired !== e.fired) begin
               $error("fired: expected %0d, got %0d", e.fired, rsp_fired);
               errors++;
            end
            if (rsp_fired_tag !== e.tag) begin
               $error("fired_tag: expected %h, got %h", e.tag, rsp_fired_tag);
               errors++;
            end
            if (rsp_fired_time !== e.when) begin
               $error("fired_time: expected %h, got %h", e.when, rsp_fired_time);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_current_time !== e.now_after) begin
               $error("current_time: expected %h, got %h", e.now_after, rsp_current_time);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   function automatic logic [tevq_pkg::TIME_BITS-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [tevq_pkg::TIME_BITS-1:0] rand_span(input int unsigned lo,
                                                                 input int unsigned hi);
      return tevq_pkg::TIME_BITS'($urandom_range(lo, hi));
   endfunction

   // Queue one command; track the time it leaves so later due times land near it.
   task automatic add_cmd(input logic [1:0] func, input logic [tevq_pkg::TIME_BITS-1:0] due,
                          input logic [tevq_pkg::PORT_TAG_BITS-1:0] tag,
                          input logic [tevq_pkg::TIME_BITS-1:0] delta, input bit drain);
      command_type                  c;
      logic [tevq_pkg::TIME_BITS:0] sum;
      c.func  = func;
      c.due   = due;
      c.tag   = tag;
      c.delta = delta;
      c.gap   = quiet ? 0 : $urandom_range(0, 11);
      c.drain = drain || ($urandom_range(0, 39) == 0);
      cmd_q.push_back(c);
      if (func == tevq_pkg::FUNC_ADVANCE) begin
         sum = {1'b0, plan_time} + {1'b0, delta};
         if (!sum[tevq_pkg::TIME_BITS]) plan_time = sum[tevq_pkg::TIME_BITS-1:0];
      end else if (func == tevq_pkg::FUNC_CLEAR) begin
         plan_time = '0;
      end
   endtask

   initial begin
      int n;
      plan_time = '0;
      quiet = 1'b0;

      // directed: extremes, ties, zero delta, wrap, clear, unused code
      add_cmd(tevq_pkg::FUNC_SCHEDULE, '0, '0, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, TIME_MAX, '1, TIME_MAX, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, 64'd5, 16'h1234, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, 64'd5, 16'h4321, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, 64'd3, 16'ha5a5, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, TIME_MAX, '1, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, 64'd5, 1'b0);
      add_cmd(FUNC_UNUSED, rand_time(), 16'($urandom), rand_time(), 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, TIME_MAX, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, TIME_MAX - 64'd5, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, 64'd1, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, '0, 16'h0f0f, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_CLEAR, TIME_MAX, '1, TIME_MAX, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, 64'd10, 16'h0001, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_CLEAR, '0, '0, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, 64'd100, 1'b0);
      add_cmd(tevq_pkg::FUNC_SCHEDULE, 64'd50, 16'h0002, '0, 1'b0);
      add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, '0, 1'b1);
      add_cmd(FUNC_UNUSED, '0, '0, '0, 1'b0);

      // random: mostly schedule-then-advance runs near the current time
      for (int s = 0; cmd_q.size() < 420; s++) begin
         quiet = ($urandom_range(0, 3) == 0);
         case ((s == 0) ? 0 : $urandom_range(1, 10))
            1: begin
               // overfill a cleared table, then fire all of it, at times part of it first
               add_cmd(tevq_pkg::FUNC_CLEAR, rand_time(), 16'($urandom), rand_time(), 1'b0);
               n = tevq_pkg::SLOTS + $urandom_range(1, 3);
               for (int i = 0; i < n; i++)
                  add_cmd(tevq_pkg::FUNC_SCHEDULE, plan_time + rand_span(0, 60),
                          16'($urandom), rand_time(), 1'b0);
               if ($urandom_range(0, 1))
                  add_cmd(tevq_pkg::FUNC_ADVANCE, rand_time(), 16'($urandom),
                          rand_span(0, 30), 1'b0);
               add_cmd(tevq_pkg::FUNC_ADVANCE, rand_time(), 16'($urandom),
                       rand_span(61, 90), 1'b0);
            end
            0: begin
               add_cmd(tevq_pkg::FUNC_CLEAR, '0, '0, '0, 1'b0);
               for (int i = 0; i < tevq_pkg::SLOTS + 1; i++)
                  add_cmd(tevq_pkg::FUNC_SCHEDULE, plan_time + rand_span(0, 7),
                          16'($urandom), '0, 1'b0);
               add_cmd(tevq_pkg::FUNC_ADVANCE, '0, '0, 64'd7, 1'b0);
            end
            2, 3: begin
               add_cmd(($urandom_range(0, 3) == 0) ? FUNC_UNUSED : 2'($urandom_range(0, 2)),
                       rand_time(), 16'($urandom), rand_time(), 1'b0);
            end
            4, 5: begin
               // push the time to its ceiling or just past it
               add_cmd(tevq_pkg::FUNC_ADVANCE, rand_time(), 16'($urandom),
                       ~plan_time + rand_span(0, 2), 1'b0);
               if (plan_time == TIME_MAX && $urandom_range(0, 1))
                  add_cmd(tevq_pkg::FUNC_CLEAR, rand_time(), 16'($urandom), rand_time(),
                          1'b0);
            end
            default: begin
               n = $urandom_range(1, 6);
               for (int i = 0; i < n; i++)
                  add_cmd(tevq_pkg::FUNC_SCHEDULE,
                          ($urandom_range(0, 7) == 0) ? rand_time()
                                                      : plan_time + rand_span(0, 40),
                          16'($urandom), rand_time(), 1'b0);
               add_cmd(tevq_pkg::FUNC_ADVANCE, rand_time(), 16'($urandom),
                       rand_span(0, 40), 1'b0);
            end
         endcase
      end

      @(negedge reset);
      while (cmd_q.size() != 0 || armed || start || owed_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d commands and checked %0d results: %0d events fired,",
               sent, checked, n_fired);
      $display("%0d schedules refused on a full table, %0d advances refused on wrap.",
               n_full, n_wrap);
      if (errors == 0 && owed_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/tevq_pkg.sv
rtl/tevq_table.sv
rtl/timed_event_queue.sv
bench/tb_top.sv
